### src/dah_pkg.sv
package dah_pkg;

    localparam int CAPACITY  = 1024;
    localparam int MAX_ARITY = 8;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int ARITY_W   = 4;
    localparam int PROD_W    = IDX_W + ARITY_W;
    localparam int DCNT_W    = 4;
    localparam int ADDR_W    = 3;

    localparam logic       OP_INSERT  = 1'b0;
    localparam logic       OP_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;
    localparam logic [ARITY_W-1:0] ARITY_MIN   = 4'd2;

    localparam logic REG_ARITY = 1'b0;

    typedef struct packed {
        logic load;
        logic set_full;
        logic set_empty;
        logic ins_start;
        logic rd_root;
        logic ext_root;
        logic ext_last;
        logic div_start;
        logic up_read;
        logic up_move;
        logic write_val;
        logic dn_start;
        logic dn_read;
        logic dn_cmp;
        logic dn_move;
        logic out_load;
    } dah_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic pos_zero;
        logic div_busy;
        logic up_greater;
        logic dn_leaf;
        logic dn_last;
        logic best_is_pos;
    } dah_sts_t;

endpackage

### src/dah_ctrl.sv
module dah_ctrl
    import dah_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dah_sts_t sts,
    output dah_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_UP_CHK   = 4'd2;
    localparam logic [3:0] S_UP_DIV   = 4'd3;
    localparam logic [3:0] S_UP_CMP   = 4'd4;
    localparam logic [3:0] S_EXT_ROOT = 4'd5;
    localparam logic [3:0] S_EXT_LAST = 4'd6;
    localparam logic [3:0] S_DN_CHK   = 4'd7;
    localparam logic [3:0] S_DN_RD    = 4'd8;
    localparam logic [3:0] S_DN_CMP   = 4'd9;
    localparam logic [3:0] S_DN_DEC   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.is_insert) begin
                    if (sts.full) begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        cmd.ins_start = 1'b1;
                        state_next    = S_UP_CHK;
                    end
                end else begin
                    if (sts.empty) begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_DONE;
                    end else begin
                        cmd.rd_root = 1'b1;
                        state_next  = S_EXT_ROOT;
                    end
                end
            end
            S_UP_CHK: begin
                if (sts.pos_zero) begin
                    cmd.write_val = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_UP_DIV;
                end
            end
            S_UP_DIV: begin
                if (!sts.div_busy) begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (sts.up_greater) begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_CHK;
                end else begin
                    cmd.write_val = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_EXT_ROOT: begin
                cmd.ext_root = 1'b1;
                state_next   = S_EXT_LAST;
            end
            S_EXT_LAST: begin
                cmd.ext_last = 1'b1;
                state_next   = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (sts.dn_leaf) begin
                    cmd.write_val = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.dn_start = 1'b1;
                    state_next   = S_DN_RD;
                end
            end
            S_DN_RD: begin
                cmd.dn_read = 1'b1;
                state_next  = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmd.dn_cmp = 1'b1;
                state_next = sts.dn_last ? S_DN_DEC : S_DN_RD;
            end
            S_DN_DEC: begin
                if (sts.best_is_pos) begin
                    cmd.write_val = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_CHK;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### src/dah_dp.sv
module dah_dp
    import dah_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ARITY_W-1:0]        arity,
    input  logic                      s_operation,
    input  logic signed [DATA_W-1:0]  s_value,
    output logic signed [DATA_W-1:0]  m_max_value,
    output logic [1:0]                m_status,
    input  dah_cmd_t                  cmd,
    output dah_sts_t                  sts
);

    logic [DATA_W-1:0] heap_mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  res_reg, res_next;
    logic [1:0]         stat_reg, stat_next;
    logic               op_reg, op_next;
    logic [IDX_W-1:0]   quo_reg, quo_next;
    logic [ARITY_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [IDX_W-1:0]   c_reg, c_next;
    logic [ARITY_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [DATA_W-1:0]  best_val_reg, best_val_next;
    logic [DATA_W-1:0]  out_val_reg, out_val_next;
    logic [1:0]         out_stat_reg, out_stat_next;

    logic [ARITY_W-1:0] eff;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  first;
    logic [ARITY_W:0]   rem_sh;
    logic               div_ge;
    logic [CNT_W-1:0]   c_inc;
    logic [CNT_W-1:0]   last_idx;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DATA_W-1:0]  wr_data;

    always_comb begin
        priority if (arity < ARITY_MIN) begin
            eff = ARITY_MIN;
        end else if (arity > ARITY_W'(MAX_ARITY)) begin
            eff = ARITY_W'(MAX_ARITY);
        end else begin
            eff = arity;
        end
    end

    assign prod     = PROD_W'(pos_reg) * PROD_W'(eff);
    assign first    = prod + PROD_W'(1);
    assign rem_sh   = {rem_reg, quo_reg[IDX_W-1]};
    assign div_ge   = rem_sh >= {1'b0, eff};
    assign c_inc    = CNT_W'(c_reg) + CNT_W'(1);
    assign last_idx = count_reg - CNT_W'(1);

    assign sts.is_insert   = (op_reg == OP_INSERT);
    assign sts.full        = (count_reg == CNT_W'(CAPACITY));
    assign sts.empty       = (count_reg == '0);
    assign sts.pos_zero    = (pos_reg == '0);
    assign sts.div_busy    = (dcnt_reg != '0);
    assign sts.up_greater  = $signed(val_reg) > $signed(rd_data_reg);
    assign sts.dn_leaf     = first >= PROD_W'(count_reg);
    assign sts.dn_last     = (c_inc >= count_reg) || (k_reg == ARITY_W'(1));
    assign sts.best_is_pos = (best_idx_reg == pos_reg);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        priority if (cmd.rd_root) begin
            rd_en = 1'b1;
        end else if (cmd.ext_root) begin
            rd_en   = 1'b1;
            rd_addr = last_idx[IDX_W-1:0];
        end else if (cmd.up_read) begin
            rd_en   = 1'b1;
            rd_addr = quo_reg;
        end else if (cmd.dn_read) begin
            rd_en   = 1'b1;
            rd_addr = c_reg;
        end else begin
            rd_en = 1'b0;
        end
    end

    always_comb begin
        wr_en   = cmd.write_val || cmd.up_move || cmd.dn_move;
        wr_addr = pos_reg;
        priority if (cmd.up_move) begin
            wr_data = rd_data_reg;
        end else if (cmd.dn_move) begin
            wr_data = best_val_reg;
        end else begin
            wr_data = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    always_comb begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        res_next      = res_reg;
        stat_next     = stat_reg;
        op_next       = op_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        out_val_next  = out_val_reg;
        out_stat_next = out_stat_reg;

        if (dcnt_reg != '0) begin
            rem_next  = div_ge ? ARITY_W'(rem_sh - {1'b0, eff}) : rem_sh[ARITY_W-1:0];
            quo_next  = {quo_reg[IDX_W-2:0], div_ge};
            dcnt_next = dcnt_reg - DCNT_W'(1);
        end

        if (cmd.load) begin
            op_next   = s_operation;
            val_next  = s_value;
            res_next  = '0;
            stat_next = ST_OK;
        end
        if (cmd.set_full) begin
            stat_next = ST_FULL;
        end
        if (cmd.set_empty) begin
            stat_next = ST_EMPTY;
        end
        if (cmd.ins_start) begin
            pos_next   = count_reg[IDX_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.div_start) begin
            quo_next  = pos_reg - IDX_W'(1);
            rem_next  = '0;
            dcnt_next = DCNT_W'(IDX_W);
        end
        if (cmd.up_move) begin
            pos_next = quo_reg;
        end
        if (cmd.ext_root) begin
            res_next   = rd_data_reg;
            count_next = last_idx;
        end
        if (cmd.ext_last) begin
            val_next = rd_data_reg;
            pos_next = '0;
        end
        if (cmd.dn_start) begin
            c_next        = first[IDX_W-1:0];
            k_next        = eff;
            best_idx_next = pos_reg;
            best_val_next = val_reg;
        end
        if (cmd.dn_cmp) begin
            if ($signed(rd_data_reg) > $signed(best_val_reg)) begin
                best_idx_next = c_reg;
                best_val_next = rd_data_reg;
            end
            c_next = c_inc[IDX_W-1:0];
            k_next = k_reg - ARITY_W'(1);
        end
        if (cmd.dn_move) begin
            pos_next = best_idx_reg;
        end
        if (cmd.out_load) begin
            out_val_next  = res_reg;
            out_stat_next = stat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            dcnt_reg  <= '0;
        end else begin
            count_reg <= count_next;
            dcnt_reg  <= dcnt_next;
        end
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        op_reg       <= op_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        c_reg        <= c_next;
        k_reg        <= k_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        out_val_reg  <= out_val_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_max_value = out_val_reg;
    assign m_status    = out_stat_reg;

endmodule

### src/d_ary_max_heap.sv
// Max-priority queue of signed 32-bit values kept as a d-ary heap in a
// 1024-entry single-port-read RAM; the arity register (0x0, reset 2, used
// clamped to 2..8) sets the branching factor. One item is worked at a time
// and gives one result item. An insert climbs the heap one level at a
// time: each level waits on a bit-serial divider that forms the 10-bit
// parent index one quotient bit at a time, and on one RAM read. An extract
// sinks one level at a time: each level reads up to d children one at a
// time through the RAM read port. Status 1 marks an extract from an empty
// heap, status 2 an insert into a full one; max_value is 0 unless an
// extract succeeds. No clearing pass is needed after reset.
module d_ary_max_heap
    import dah_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_max_value,
    output logic [1:0]               m_status
);

    logic [ARITY_W-1:0] arity_reg, arity_next;
    logic               reg_sel;
    dah_cmd_t           cmd;
    dah_sts_t           sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_ARITY);
    assign prdata  = reg_sel ? {{(32 - ARITY_W){1'b0}}, arity_reg} : '0;

    always_comb begin
        arity_next = arity_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            arity_next = pwdata[ARITY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arity_reg <= ARITY_RESET;
        end else begin
            arity_reg <= arity_next;
        end
    end

    dah_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dah_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .arity       (arity_reg),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_max_value (m_max_value),
        .m_status    (m_status),
        .cmd         (cmd),
        .sts         (sts)
    );

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_EMPTY || m_status == ST_FULL))
        else $error("bad status code");

    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_max_value == '0))
        else $error("nonzero value with failure status");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item taken while busy");

endmodule
